// ===== rtl/trs_pkg.sv =====
// trs_pkg: shared widths, register indexes, reset values and the
// command/status structs between the splitter controller and datapath.
// Used by every module of the transfer range splitter; depends on nothing.
`default_nettype none

package trs_pkg;

  localparam int SZ_W           = 48;  // byte offsets and lengths
  localparam int DFLT_W         = 7;   // default_chunks register
  localparam int CFG_W          = 48;  // widest register
  localparam int CFG_IDX_W      = 2;
  localparam int IDX_OUT_W      = 6;
  localparam int CNT_OUT_W      = 7;
  localparam int DIV_CNT_W      = $clog2(SZ_W);
  localparam int MAX_CHUNKS_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_CHUNKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHUNK_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK_SIZE = 2'd2;

  localparam logic [DFLT_W-1:0] DFLT_RST = 7'd5;
  localparam logic [SZ_W-1:0]   MIN_RST  = 48'd65536;
  localparam logic [SZ_W-1:0]   MAX_RST  = 48'd16777216;

  typedef enum logic [1:0] {
    DIV_DFLT  = 2'd0,
    DIV_MIN   = 2'd1,
    DIV_MAX   = 2'd2,
    DIV_COUNT = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     emit_empty;
    logic     div_start;
    div_sel_t div_sel;
    logic     count_dflt;
    logic     count_div;
    logic     body_ld;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic total_zero;
    logic div_done;
    logic below_min;
    logic above_max;
    logic emit_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/trs_div.sv =====
// trs_div: restoring divider, one quotient bit per cycle.
// Depends on trs_pkg for the operand width.
`default_nettype none

module trs_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start_i,
  input  wire logic [trs_pkg::SZ_W-1:0] dividend_i,
  input  wire logic [trs_pkg::SZ_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [trs_pkg::SZ_W-1:0]      quo_o,
  output logic [trs_pkg::SZ_W-1:0]      rem_o
);

  logic [trs_pkg::SZ_W-1:0]      rem_r, rem_nxt;
  logic [trs_pkg::SZ_W-1:0]      quo_r, quo_nxt;
  logic [trs_pkg::SZ_W-1:0]      dvs_r;
  logic [trs_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r, done_r;
  logic [trs_pkg::SZ_W:0]        rem_sh;
  logic [trs_pkg::SZ_W+1:0]      diff;
  logic                          ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[trs_pkg::SZ_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge      = ~diff[trs_pkg::SZ_W+1];
    rem_nxt = ge ? diff[trs_pkg::SZ_W-1:0] : rem_sh[trs_pkg::SZ_W-1:0];
    quo_nxt = {quo_r[trs_pkg::SZ_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == trs_pkg::DIV_CNT_W'(trs_pkg::SZ_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= '0;
      quo_r <= dividend_i;
      dvs_r <= divisor_i;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done_o = done_r;
  assign quo_o  = quo_r;
  assign rem_o  = rem_r;

endmodule

`default_nettype wire

// ===== rtl/trs_dp.sv =====
// trs_dp: splitter datapath - configuration registers, count selection,
// body/tail sizes, chunk walk and the registered result.
// Depends on trs_pkg and trs_div.
`default_nettype none

module trs_dp #(
  parameter int MAX_CHUNKS = trs_pkg::MAX_CHUNKS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire trs_pkg::cmd_t                      cmd_i,
  output trs_pkg::stat_t                          stat_o,
  input  wire logic                               cfg_we,
  input  wire logic [trs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [trs_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic [trs_pkg::SZ_W-1:0]           in_total_size,
  output logic                                    out_valid,
  output logic [trs_pkg::SZ_W-1:0]                out_chunk_start,
  output logic [trs_pkg::SZ_W-1:0]                out_chunk_length,
  output logic [trs_pkg::IDX_OUT_W-1:0]           out_chunk_index,
  output logic [trs_pkg::CNT_OUT_W-1:0]           out_chunk_count,
  output logic                                    out_count_clamped,
  output logic                                    out_last_chunk
);

  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam logic [trs_pkg::SZ_W-1:0]   MAX_WIDE = trs_pkg::SZ_W'(MAX_CHUNKS);
  localparam logic [trs_pkg::DFLT_W-1:0] MAX_DFLT = trs_pkg::DFLT_W'(MAX_CHUNKS);
  localparam logic [CNT_W-1:0]           MAX_CNT  = CNT_W'(MAX_CHUNKS);

  logic [trs_pkg::DFLT_W-1:0] dflt_r;
  logic [trs_pkg::SZ_W-1:0]   min_r, max_r;
  logic [trs_pkg::DFLT_W-1:0] dflt_eff;
  logic [trs_pkg::SZ_W-1:0]   min_eff, max_eff;

  logic [trs_pkg::SZ_W-1:0]   total_r;
  trs_pkg::div_sel_t          div_sel_r;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       clamp_r, clamp_nxt;
  logic [trs_pkg::SZ_W-1:0]   body_r, tail_r, rem_r;
  logic [CNT_W-1:0]           left_r, cnt_out_r;
  logic [IDX_W-1:0]           idx_r;

  logic [trs_pkg::SZ_W-1:0]   divisor;
  logic                       div_done;
  logic [trs_pkg::SZ_W-1:0]   div_q, div_r;
  logic [trs_pkg::SZ_W-1:0]   len, rem_nxt;

  logic                       out_valid_r;
  logic [trs_pkg::SZ_W-1:0]   out_start_r, out_len_r;
  logic [IDX_W-1:0]           out_idx_r;
  logic [CNT_W-1:0]           out_cnt_r;
  logic                       out_clamp_r, out_last_r;

  // a zero register behaves as one
  assign dflt_eff = (dflt_r == '0) ? trs_pkg::DFLT_W'(1) : dflt_r;
  assign min_eff  = (min_r == '0) ? trs_pkg::SZ_W'(1) : min_r;
  assign max_eff  = (max_r == '0) ? trs_pkg::SZ_W'(1) : max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r <= trs_pkg::DFLT_RST;
      min_r  <= trs_pkg::MIN_RST;
      max_r  <= trs_pkg::MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        trs_pkg::REG_DEFAULT_CHUNKS: dflt_r <= cfg_wdata[trs_pkg::DFLT_W-1:0];
        trs_pkg::REG_MIN_CHUNK_SIZE: min_r  <= cfg_wdata[trs_pkg::SZ_W-1:0];
        trs_pkg::REG_MAX_CHUNK_SIZE: max_r  <= cfg_wdata[trs_pkg::SZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      trs_pkg::DIV_DFLT:  divisor = trs_pkg::SZ_W'(dflt_eff);
      trs_pkg::DIV_MIN:   divisor = min_eff;
      trs_pkg::DIV_MAX:   divisor = max_eff;
      trs_pkg::DIV_COUNT: divisor = trs_pkg::SZ_W'(count_r);
      default:            divisor = trs_pkg::SZ_W'(1);
    endcase
  end

  trs_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cmd_i.div_start),
    .dividend_i (total_r),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quo_o      (div_q),
    .rem_o      (div_r)
  );

  // chunk count from the default or from the limit division, saturated
  always_comb begin
    count_nxt = MAX_CNT;
    clamp_nxt = 1'b0;
    if (cmd_i.count_dflt) begin
      if (dflt_eff > MAX_DFLT) begin
        clamp_nxt = 1'b1;
      end else begin
        count_nxt = CNT_W'(dflt_eff);
      end
    end else if (div_sel_r == trs_pkg::DIV_MAX) begin
      if (div_q >= MAX_WIDE) begin
        clamp_nxt = 1'b1;
      end else begin
        count_nxt = div_q[CNT_W-1:0] + 1'b1;
      end
    end else begin
      if (div_q > MAX_WIDE) begin
        clamp_nxt = 1'b1;
      end else if (div_q == '0) begin
        count_nxt = CNT_W'(1);
      end else begin
        count_nxt = div_q[CNT_W-1:0];
      end
    end
  end

  assign len     = (idx_r == '0) ? tail_r : body_r;
  assign rem_nxt = rem_r - len;

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      total_r <= in_total_size;
    end
    if (cmd_i.div_start) begin
      div_sel_r <= cmd_i.div_sel;
    end
    if (cmd_i.count_dflt || cmd_i.count_div) begin
      count_r <= count_nxt;
      clamp_r <= clamp_nxt;
    end
    if (cmd_i.body_ld) begin
      body_r    <= div_q;
      tail_r    <= div_q + div_r;
      rem_r     <= total_r;
      idx_r     <= '0;
      // an empty body leaves the whole transfer in the tail chunk
      left_r    <= (div_q == '0) ? CNT_W'(1) : count_r;
      cnt_out_r <= (div_q == '0) ? CNT_W'(1) : count_r;
    end else if (cmd_i.emit) begin
      rem_r  <= rem_nxt;
      idx_r  <= idx_r + 1'b1;
      left_r <= left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.emit | cmd_i.emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit_empty) begin
      out_start_r <= '0;
      out_len_r   <= '0;
      out_idx_r   <= '0;
      out_cnt_r   <= '0;
      out_clamp_r <= 1'b0;
      out_last_r  <= 1'b1;
    end else if (cmd_i.emit) begin
      out_start_r <= rem_nxt;
      out_len_r   <= len;
      out_idx_r   <= idx_r;
      out_cnt_r   <= cnt_out_r;
      out_clamp_r <= clamp_r;
      out_last_r  <= (left_r == CNT_W'(1));
    end
  end

  assign stat_o.total_zero = (in_total_size == '0);
  assign stat_o.div_done   = div_done;
  assign stat_o.below_min  = (div_q < min_eff);
  assign stat_o.above_max  = (div_q > max_eff);
  assign stat_o.emit_last  = (left_r == CNT_W'(1));

  assign out_valid         = out_valid_r;
  assign out_chunk_start   = out_start_r;
  assign out_chunk_length  = out_len_r;
  assign out_chunk_index   = trs_pkg::IDX_OUT_W'(out_idx_r);
  assign out_chunk_count   = trs_pkg::CNT_OUT_W'(out_cnt_r);
  assign out_count_clamped = out_clamp_r;
  assign out_last_chunk    = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/trs_ctrl.sv =====
// trs_ctrl: splitter sequencer - default division, optional limit division,
// body division, then one chunk per cycle; a zero-size item gets one empty result.
// Depends on trs_pkg for the command and status structs.
`default_nettype none

module trs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire trs_pkg::stat_t stat_i,
  output trs_pkg::cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP1 = 7'b0000010,
    ST_DIV1  = 7'b0000100,
    ST_DIV2  = 7'b0001000,
    ST_PREP3 = 7'b0010000,
    ST_DIV3  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (stat_i.total_zero) begin
            cmd_o.emit_empty = 1'b1;
          end else begin
            state_nxt = ST_PREP1;
          end
        end
      end
      ST_PREP1: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = trs_pkg::DIV_DFLT;
        state_nxt       = ST_DIV1;
      end
      ST_DIV1: begin
        if (stat_i.div_done) begin
          // minimum test wins over the maximum test
          if (stat_i.below_min) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = trs_pkg::DIV_MIN;
            state_nxt       = ST_DIV2;
          end else if (stat_i.above_max) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = trs_pkg::DIV_MAX;
            state_nxt       = ST_DIV2;
          end else begin
            cmd_o.count_dflt = 1'b1;
            state_nxt        = ST_PREP3;
          end
        end
      end
      ST_DIV2: begin
        if (stat_i.div_done) begin
          cmd_o.count_div = 1'b1;
          state_nxt       = ST_PREP3;
        end
      end
      ST_PREP3: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = trs_pkg::DIV_COUNT;
        state_nxt       = ST_DIV3;
      end
      ST_DIV3: begin
        if (stat_i.div_done) begin
          cmd_o.body_ld = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (stat_i.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/transfer_range_splitter.sv =====
// transfer_range_splitter: top level, joins the sequencer and the datapath.
// Depends on trs_pkg, trs_ctrl and trs_dp (which holds trs_div).
//
// Usage:
//   An item (in_total_size) is taken at a clock edge with start high and busy
//   low. Busy stays high until the last chunk of the item is on the out_ ports.
//   Results appear on the out_ ports for one cycle each, marked by out_valid,
//   tail chunk first in descending start order; out_last_chunk marks the
//   final one. The receiver cannot stall; chunks of one item come on
//   consecutive cycles.
//   A zero-size item gives its single empty result in the cycle after
//   acceptance, busy stays low. Otherwise the count and sizes come from two
//   or three divisions on one shared bit-serial divider (one quotient bit
//   per cycle), and then the chunks follow, one chunk per cycle.
//   Registers are written through cfg_we/cfg_index/cfg_wdata; the user must do so
//   only while busy is low (the block does not enforce it); writes to unlisted indexes are ignored.
//   Reset (rst_n low, synchronous) returns to idle, drops out_valid and
//   restores the register reset values.
`default_nettype none

module transfer_range_splitter #(
  parameter int MAX_CHUNKS = trs_pkg::MAX_CHUNKS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [trs_pkg::SZ_W-1:0]       in_total_size,
  output logic                                out_valid,
  output logic [trs_pkg::SZ_W-1:0]            out_chunk_start,
  output logic [trs_pkg::SZ_W-1:0]            out_chunk_length,
  output logic [trs_pkg::IDX_OUT_W-1:0]       out_chunk_index,
  output logic [trs_pkg::CNT_OUT_W-1:0]       out_chunk_count,
  output logic                                out_count_clamped,
  output logic                                out_last_chunk,
  input  wire logic                           cfg_we,
  input  wire logic [trs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [trs_pkg::CFG_W-1:0]      cfg_wdata
);

  trs_pkg::cmd_t  cmd;
  trs_pkg::stat_t stat;

  trs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  trs_dp #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_total_size     (in_total_size),
    .out_valid         (out_valid),
    .out_chunk_start   (out_chunk_start),
    .out_chunk_length  (out_chunk_length),
    .out_chunk_index   (out_chunk_index),
    .out_chunk_count   (out_chunk_count),
    .out_count_clamped (out_count_clamped),
    .out_last_chunk    (out_last_chunk)
  );

endmodule

`default_nettype wire

// ===== rtl/trs_chk.sv =====
// trs_chk: port-level checks for transfer_range_splitter, bound to the top.
// Depends on trs_pkg for port widths.
`default_nettype none

module trs_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [trs_pkg::SZ_W-1:0]      in_total_size,
  input wire logic                          out_valid,
  input wire logic [trs_pkg::SZ_W-1:0]      out_chunk_start,
  input wire logic [trs_pkg::SZ_W-1:0]      out_chunk_length,
  input wire logic [trs_pkg::IDX_OUT_W-1:0] out_chunk_index,
  input wire logic [trs_pkg::CNT_OUT_W-1:0] out_chunk_count,
  input wire logic                          out_last_chunk
);

  // chunks of one item are contiguous and walk down to offset zero
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_chunk |=> out_valid &&
      (out_chunk_start + out_chunk_length == $past(out_chunk_start)))
    else $error("chunk not adjacent to the previous one");

  a_last_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_chunk |-> out_chunk_start == '0)
    else $error("last chunk does not start at offset zero");

  a_busy_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_chunk |-> busy)
    else $error("chunk walk in progress while idle");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_total_size != '0 |=> busy)
    else $error("nonempty item accepted without going busy");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chunk_count != '0 |->
      trs_pkg::CNT_OUT_W'(out_chunk_index) < out_chunk_count)
    else $error("chunk index beyond chunk count");

endmodule

bind transfer_range_splitter trs_chk u_trs_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_total_size    (in_total_size),
  .out_valid        (out_valid),
  .out_chunk_start  (out_chunk_start),
  .out_chunk_length (out_chunk_length),
  .out_chunk_index  (out_chunk_index),
  .out_chunk_count  (out_chunk_count),
  .out_last_chunk   (out_last_chunk)
);

`default_nettype wire

// ===== tb/sv/tb_transfer_range_splitter.sv =====
// tb_transfer_range_splitter: self-checking bench for the transfer range splitter.
// Predicts every chunk of each accepted transfer and checks the out_ strobe stream
// against it, over many register settings. Depends on trs_pkg and the RTL top.
module tb_transfer_range_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CHUNKS = trs_pkg::MAX_CHUNKS_DEF;
  localparam int SZ_W       = trs_pkg::SZ_W;
  localparam int DFLT_W     = trs_pkg::DFLT_W;
  localparam int CFG_W      = trs_pkg::CFG_W;
  localparam int CFG_IDX_W  = trs_pkg::CFG_IDX_W;
  localparam int IDX_OUT_W  = trs_pkg::IDX_OUT_W;
  localparam int CNT_OUT_W  = trs_pkg::CNT_OUT_W;
  localparam logic [SZ_W-1:0] SIZE_MAX = '1;

  typedef struct packed {
    logic [SZ_W-1:0]      start;
    logic [SZ_W-1:0]      length;
    logic [IDX_OUT_W-1:0] index;
    logic [CNT_OUT_W-1:0] count;
    logic                 clamped;
    logic                 last;
  } chunk_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic [SZ_W-1:0]      in_total_size = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = trs_pkg::REG_DEFAULT_CHUNKS;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic                 busy;
  logic                 out_valid;
  logic [SZ_W-1:0]      out_chunk_start;
  logic [SZ_W-1:0]      out_chunk_length;
  logic [IDX_OUT_W-1:0] out_chunk_index;
  logic [CNT_OUT_W-1:0] out_chunk_count;
  logic                 out_count_clamped;
  logic                 out_last_chunk;

  // shadow copy of the splitter registers
  logic [DFLT_W-1:0] set_dflt = trs_pkg::DFLT_RST;
  logic [SZ_W-1:0]   set_min  = trs_pkg::MIN_RST;
  logic [SZ_W-1:0]   set_max  = trs_pkg::MAX_RST;

  chunk_t pending_chunks[$];
  chunk_t got_chunk, want_chunk;
  bit     allow_idle = 1'b1;
  int     mismatches = 0;
  int     transfers_sent = 0;
  int     chunks_checked = 0;
  int     clamped_transfers = 0;
  int     empty_transfers = 0;
  int     settings_used = 1;

  transfer_range_splitter #(.MAX_CHUNKS(MAX_CHUNKS)) u_top (
    .clk, .rst_n, .start, .busy, .in_total_size,
    .out_valid, .out_chunk_start, .out_chunk_length, .out_chunk_index,
    .out_chunk_count, .out_count_clamped, .out_last_chunk,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d chunks still expected", pending_chunks.size());
    $display("TEST FAILED");
    $finish;
  end

  // expected chunk list for one transfer under the current registers
  function automatic void split_transfer(input logic [SZ_W-1:0] total);
    logic [63:0] t, dflt, mn, mx, count, body, tail, remaining, len, emitted;
    logic        clamp;
    chunk_t      c;
    int          i;
    t    = 64'(total);
    dflt = (set_dflt == 0) ? 64'd1 : 64'(set_dflt);
    mn   = (set_min == 0) ? 64'd1 : 64'(set_min);
    mx   = (set_max == 0) ? 64'd1 : 64'(set_max);
    if (t == 0) begin
      c = '0;
      c.last = 1'b1;
      pending_chunks.push_back(c);
      empty_transfers++;
      return;
    end
    count = dflt;
    body  = t / count;
    // the minimum test wins even when the maximum is below it
    if (body < mn) begin
      count = t / mn;
      if (count == 0) count = 64'd1;
    end else if (body > mx) begin
      count = t / mx + 64'd1;
    end
    clamp = 1'b0;
    if (count > 64'(MAX_CHUNKS)) begin
      count = 64'(MAX_CHUNKS);
      clamp = 1'b1;
    end
    if (clamp) clamped_transfers++;
    body = t / count;
    tail = body + t % count;
    // zero body: the tail carries everything and is the only chunk
    emitted   = (body != 0) ? count : 64'd1;
    remaining = t;
    for (i = 0; i < int'(emitted); i++) begin
      len = (i == 0) ? tail : body;
      if (len > remaining) len = remaining;
      remaining -= len;
      c.start   = remaining[SZ_W-1:0];
      c.length  = len[SZ_W-1:0];
      c.index   = IDX_OUT_W'(i);
      c.count   = emitted[CNT_OUT_W-1:0];
      c.clamped = clamp;
      c.last    = (i == int'(emitted) - 1);
      pending_chunks.push_back(c);
    end
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h got %0h (chunk %0d)", name, want, got,
                 chunks_checked);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_chunk = '{out_chunk_start, out_chunk_length, out_chunk_index,
                    out_chunk_count, out_count_clamped, out_last_chunk};
      if (pending_chunks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected chunk: start %0h length %0h index %0d",
                   got_chunk.start, got_chunk.length, got_chunk.index);
      end else begin
        want_chunk = pending_chunks.pop_front();
        check_field("chunk_start", want_chunk.start, got_chunk.start);
        check_field("chunk_length", want_chunk.length, got_chunk.length);
        check_field("chunk_index", want_chunk.index, got_chunk.index);
        check_field("chunk_count", want_chunk.count, got_chunk.count);
        check_field("count_clamped", want_chunk.clamped, got_chunk.clamped);
        check_field("last_chunk", want_chunk.last, got_chunk.last);
      end
      chunks_checked++;
    end
  end

  // called at a rising edge; returns at the edge that takes the item
  task automatic send_item(input logic [SZ_W-1:0] total);
    while (allow_idle && $urandom_range(0, 99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_total_size <= total;
    do @(posedge clk); while (busy);
    split_transfer(total);
    transfers_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_chunks.size() != 0 || busy) @(posedge clk);
    @(posedge clk);
  endtask

  // only called with the splitter idle
  task automatic set_limits(input logic [DFLT_W-1:0] d, input logic [SZ_W-1:0] mn, mx);
    cfg_we    <= 1'b1;
    cfg_index <= trs_pkg::REG_DEFAULT_CHUNKS;
    cfg_wdata <= CFG_W'(d);
    @(posedge clk);
    cfg_index <= trs_pkg::REG_MIN_CHUNK_SIZE;
    cfg_wdata <= mn;
    @(posedge clk);
    cfg_index <= trs_pkg::REG_MAX_CHUNK_SIZE;
    cfg_wdata <= mx;
    @(posedge clk);
    cfg_we   <= 1'b0;
    set_dflt  = d;
    set_min   = mn;
    set_max   = mx;
    settings_used++;
  endtask

  function automatic logic [SZ_W-1:0] rand_size();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[SZ_W-1:0];
  endfunction

  function automatic logic [SZ_W-1:0] rand_scaled();
    return rand_size() >> $urandom_range(0, SZ_W - 1);
  endfunction

  // totals weighted toward the count boundaries of the current registers
  function automatic logic [SZ_W-1:0] rand_total();
    logic [63:0] base, mn, mx, dflt;
    int          roll;
    mn   = (set_min == 0) ? 64'd1 : 64'(set_min);
    mx   = (set_max == 0) ? 64'd1 : 64'(set_max);
    dflt = (set_dflt == 0) ? 64'd1 : 64'(set_dflt);
    roll = $urandom_range(0, 99);
    if (roll < 25) return rand_size();
    if (roll < 45) return rand_scaled();
    if (roll < 70) base = mn * $urandom_range(0, 70);
    else if (roll < 90) base = mx * $urandom_range(0, 70);
    else if (roll < 95) base = dflt * mn;
    else base = dflt * mx;
    base = base + $urandom_range(0, 2) - 1;
    return base[SZ_W-1:0];
  endfunction

  task automatic send_list(input logic [SZ_W-1:0] sizes[$]);
    foreach (sizes[i]) send_item(sizes[i]);
  endtask

  task automatic test_reset_limits();
    wait_drained();
    send_list('{48'd0, 48'd1, 48'd100, 48'd65535, 48'd65536, 48'd327679, 48'd327680,
                48'd83886080, 48'd83886081, SIZE_MAX});
  endtask

  task automatic test_extreme_limits();
    wait_drained();
    set_limits(7'd1, 48'd1, SIZE_MAX);
    send_list('{48'd1, SIZE_MAX});
    wait_drained();
    set_limits(7'd64, SIZE_MAX, SIZE_MAX);
    send_list('{48'd12345, SIZE_MAX});
  endtask

  // zero registers act as one; small totals then give a zero body
  task automatic test_zero_registers();
    wait_drained();
    set_limits(7'd0, 48'd0, 48'd0);
    send_list('{48'd0, 48'd1, 48'd2, 48'd37, 48'd63, 48'd64, 48'd1000});
  endtask

  task automatic test_clamp_and_inverted();
    wait_drained();
    set_limits(7'd127, 48'd1, SIZE_MAX);
    send_list('{48'd1000, 48'd126});
    wait_drained();
    set_limits(7'd10, 48'h4000_0000, 48'h10_0000);
    send_list('{48'h3_0000_0000, 48'h27_ffff_ffff});
  endtask

  task automatic test_random();
    logic [DFLT_W-1:0] d;
    logic [SZ_W-1:0]   mn, mx, swap;
    int                roll;
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      roll = $urandom_range(0, 99);
      if (roll < 8) d = '0;
      else if (roll < 18) d = DFLT_W'($urandom_range(65, 127));
      else d = DFLT_W'($urandom_range(1, 64));
      mn = rand_scaled();
      mx = rand_scaled();
      if ($urandom_range(0, 99) < 75 && mx < mn) begin
        swap = mn;
        mn   = mx;
        mx   = swap;
      end
      if (phase == 0) mx = SIZE_MAX;
      if (phase == 1) mn = 48'd1;
      set_limits(d, mn, mx);
      // one phase runs back to back with no sender gaps
      allow_idle = (phase != 3);
      repeat (48) send_item(rand_total());
    end
    allow_idle = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_limits();
    test_extreme_limits();
    test_zero_registers();
    test_clamp_and_inverted();
    test_random();
    wait_drained();
    repeat (250) @(posedge clk);
    $display("%0d transfers split into %0d chunks under %0d register settings",
             transfers_sent, chunks_checked, settings_used);
    $display("%0d transfers had a saturated count, %0d were empty, %0d mismatches",
             clamped_transfers, empty_transfers, mismatches);
    if (mismatches == 0 && pending_chunks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
